// ===== design/pointer_angle_affine_rotation_top_assert.svh =====
// Assertion macros shared by the pointer angle rotation block.
`ifndef POINTER_ANGLE_AFFINE_ROTATION_TOP_ASSERT_SVH
`define POINTER_ANGLE_AFFINE_ROTATION_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PAR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PAR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/par_pkg.sv =====
// Package with shared types and tables of the pointer angle rotation block.
`timescale 1ns / 1ps
package par_pkg;
    localparam int ITERS = 30;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    // Configuration register indexes
    localparam logic [1:0] REG_PX = 2'd0;
    localparam logic [1:0] REG_PY = 2'd1;
    localparam logic [1:0] REG_MX = 2'd2;
    localparam logic [1:0] REG_MY = 2'd3;

    typedef logic signed [33:0] word_t;

    // Cell payload: vectoring and rotation share a cell format
    typedef struct packed {
        logic  valid;
        word_t x;
        word_t y;
        logic signed [33:0] z;
        logic  neg;
        logic [31:0] angle;
        logic [7:0] px;
        logic [7:0] py;
        logic [7:0] mx;
        logic [7:0] my;
    } cell_t;

    function automatic logic signed [33:0] atan_entry(input int i);
        logic [31:0] t;
        begin
            unique case (i)
                0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
                3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
                6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
                9: t = 32'h00145F2E; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
                15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
                18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
                21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
                24: t = 32'h00000028; 25: t = 32'h00000014; 26: t = 32'h0000000A;
                27: t = 32'h00000005; 28: t = 32'h00000002; 29: t = 32'h00000001;
                default: t = 32'h0;
            endcase
            atan_entry = $signed({2'b00, t});
        end
    endfunction
endpackage

// ===== design/par_cell.sv =====
// One CORDIC micro-rotation cell, vectoring or rotation mode.
`timescale 1ns / 1ps
module par_cell #(
    parameter int STEP   = 0,
    parameter bit ROTATE = 1'b0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  par_pkg::cell_t  din,
    output par_pkg::cell_t  dout
);
    import par_pkg::*;

    cell_t cell_reg;
    cell_t cell_next;
    word_t xs;
    word_t ys;
    logic  dir;

    // Shift and rotate by one table angle
    always_comb
    begin
        xs = din.x >>> STEP;
        ys = din.y >>> STEP;
        dir = ROTATE ? !din.z[33] : (din.y > 0);
        cell_next = din;
        if (ROTATE ? dir : dir)
        begin
            if (ROTATE)
            begin
                cell_next.x = din.x - ys;
                cell_next.y = din.y + xs;
                cell_next.z = din.z - atan_entry(STEP);
            end
            else
            begin
                cell_next.x = din.x + ys;
                cell_next.y = din.y - xs;
                cell_next.z = din.z + atan_entry(STEP);
            end
        end
        else
        begin
            if (ROTATE)
            begin
                cell_next.x = din.x + ys;
                cell_next.y = din.y - xs;
                cell_next.z = din.z + atan_entry(STEP);
            end
            else
            begin
                cell_next.x = din.x - ys;
                cell_next.y = din.y + xs;
                cell_next.z = din.z - atan_entry(STEP);
            end
        end
    end

    // Hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (en)
            cell_reg <= cell_next;
    end

    assign dout = cell_reg;
endmodule

// ===== design/pointer_angle_affine_rotation_top.sv =====
// Top level: pointer angle, rotation matrix and origin through a CORDIC cell chain.
// Throughput: one beat per cycle while the output is not stalled; the chain of 60
// CORDIC cells advances as one pipe.
// The chain stalls as a whole only while the output beat waits for tready.
// Reset (rst_n, asynchronous) clears all valid flags and loads the register defaults.
`timescale 1ns / 1ps
module pointer_angle_affine_rotation_top #(
    parameter int ANGLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // touch_x[7:0], touch_y[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [103:0] m_tdata   // angle_turns[15:0], mat_a, mat_b, mat_c, mat_d (10 each),
                                   // origin_x[74:56], origin_y[93:75], zero fill
);
    import par_pkg::*;

    localparam int SH = 32 - ANGLE_BITS;

    logic [7:0] px_reg, py_reg, mx_reg, my_reg;
    logic en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= 8'd128; py_reg <= 8'd96; mx_reg <= 8'd64; my_reg <= 8'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PX: px_reg <= cfg_data;
                REG_PY: py_reg <= cfg_data;
                REG_MX: mx_reg <= cfg_data;
                REG_MY: my_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 0: deltas and half-turn fold
    cell_t s0_reg;
    logic  out_valid_reg;
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    cell_t s0_next;
    logic signed [9:0] dx, dy;
    always_comb
    begin
        dx = $signed({2'b0, s_tdata[7:0]}) - $signed({2'b0, px_reg});
        dy = $signed({2'b0, s_tdata[15:8]}) - $signed({2'b0, py_reg});
        s0_next = '0;
        s0_next.valid = s_tvalid;
        s0_next.neg = (dx == 0) && (dy == 0);
        s0_next.px = px_reg; s0_next.py = py_reg;
        s0_next.mx = mx_reg; s0_next.my = my_reg;
        if (dx[9])
        begin
            s0_next.x = {-{{4{dx[9]}}, dx}, 20'd0};
            s0_next.y = {-{{4{dy[9]}}, dy}, 20'd0};
            s0_next.z = 34'sh080000000;
        end
        else
        begin
            s0_next.x = {{{4{dx[9]}}, dx}, 20'd0};
            s0_next.y = {{{4{dy[9]}}, dy}, 20'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s0_reg <= '0;
        else if (en) s0_reg <= s0_next;
    end

    // Vectoring chain
    cell_t vc [0:ITERS];
    assign vc[0] = s0_reg;
    genvar g;
    generate
        for (g = 0; g < ITERS; g++)
        begin : g_vec
            par_cell #(.STEP(g), .ROTATE(1'b0)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .din(vc[g]), .dout(vc[g+1]));
        end
    endgenerate

    // Stage 1: quantise angle and fold into rotation range
    cell_t s1_reg, s1_next;
    logic [32:0] zr;
    logic [31:0] ang, theta;
    always_comb
    begin
        zr = {1'b0, vc[ITERS].z[31:0]} + (33'd1 << (SH - 1));
        ang = vc[ITERS].neg ? 32'd0
              : ((zr[31:0] >> SH) & ((32'd1 << ANGLE_BITS) - 32'd1));
        theta = ang << SH;
        s1_next = vc[ITERS];
        s1_next.angle = ang;
        s1_next.neg = theta[31] ^ theta[30];
        if (s1_next.neg) theta = theta + 32'h80000000;
        s1_next.z = {{2{theta[31]}}, theta};
        s1_next.x = GAIN_Q30;
        s1_next.y = '0;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_reg <= '0;
        else if (en) s1_reg <= s1_next;
    end

    // Rotation chain
    cell_t rc [0:ITERS];
    assign rc[0] = s1_reg;
    generate
        for (g = 0; g < ITERS; g++)
        begin : g_rot
            par_cell #(.STEP(g), .ROTATE(1'b1)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(en), .din(rc[g]), .dout(rc[g+1]));
        end
    endgenerate

    // Stage 2: round to Q20, negate, clamp
    logic signed [22:0] c_reg, s_reg, c_next, s_next;
    logic v2_reg;
    logic [15:0] ang2_reg;
    logic [7:0] px2_reg, py2_reg, mx2_reg, my2_reg;

    function automatic logic signed [22:0] rq(input logic signed [33:0] v, input logic n);
        logic signed [33:0] a;
        logic signed [33:0] r;
        begin
            a = v[33] ? -v : v;
            r = (a + 34'sd512) >>> 10;
            if (v[33] ^ n) r = -r;
            if (r > 34'sd1048576) r = 34'sd1048576;
            if (r < -34'sd1048576) r = -34'sd1048576;
            rq = r[22:0];
        end
    endfunction

    always_comb
    begin
        c_next = rq(rc[ITERS].x, rc[ITERS].neg);
        s_next = rq(rc[ITERS].y, rc[ITERS].neg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (en) v2_reg <= rc[ITERS].valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next; s_reg <= s_next;
            ang2_reg <= rc[ITERS].angle[15:0];
            px2_reg <= rc[ITERS].px; py2_reg <= rc[ITERS].py;
            mx2_reg <= rc[ITERS].mx; my2_reg <= rc[ITERS].my;
        end
    end

    // Stage 3: products
    logic signed [32:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [9:0] base_x_reg, base_y_reg;
    logic signed [22:0] c3_reg, s3_reg;
    logic v3_reg;
    logic [15:0] ang3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxc_reg <= $signed({1'b0, px2_reg}) * c_reg;
            pys_reg <= $signed({1'b0, py2_reg}) * s_reg;
            pyc_reg <= $signed({1'b0, py2_reg}) * c_reg;
            pxs_reg <= $signed({1'b0, px2_reg}) * s_reg;
            base_x_reg <= $signed({2'b0, px2_reg}) - $signed({2'b0, mx2_reg});
            base_y_reg <= $signed({2'b0, py2_reg}) - $signed({2'b0, my2_reg});
            c3_reg <= c_reg; s3_reg <= s_reg; ang3_reg <= ang2_reg;
        end
    end

    // Output stage: sum, truncate toward zero
    function automatic logic signed [21:0] tz(input logic signed [34:0] v);
        logic signed [34:0] a;
        begin
            a = v[34] ? -v : v;
            a = a >>> 12;
            tz = v[34] ? -a[21:0] : a[21:0];
        end
    endfunction

    logic signed [34:0] ox, oy;
    logic signed [21:0] ca, sa, sn, oxt, oyt;
    always_comb
    begin
        ox = ($signed({{5{base_x_reg[9]}}, base_x_reg, 20'd0}))
             - {{2{pxc_reg[32]}}, pxc_reg} - {{2{pys_reg[32]}}, pys_reg};
        oy = ($signed({{5{base_y_reg[9]}}, base_y_reg, 20'd0}))
             - {{2{pyc_reg[32]}}, pyc_reg} + {{2{pxs_reg[32]}}, pxs_reg};
        oxt = tz(ox);
        oyt = tz(oy);
        ca = tz({{12{c3_reg[22]}}, c3_reg});
        sa = tz({{12{s3_reg[22]}}, s3_reg});
        sn = tz(-{{12{s3_reg[22]}}, s3_reg});
    end

    logic [103:0] out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (en) out_valid_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {10'd0, oyt[18:0], oxt[18:0], ca[9:0], sn[9:0], sa[9:0],
                        ca[9:0], ang3_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `include "pointer_angle_affine_rotation_top_assert.svh"
    `PAR_ASSERT_IMP(a_ready_when_empty, !out_valid_reg, s_tready)
    `PAR_ASSERT_NXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PAR_ASSERT_IMP(a_mat_ad_equal, m_tvalid, m_tdata[25:16] == m_tdata[55:46])
endmodule
